// ===== hdl/pidaw_pkg.sv =====
// Shared widths, register indexes, reset values and saturation helpers for the PID block.
package pidaw_pkg;

  localparam int DATA_W    = 32;
  localparam int PERIOD_W  = 31;
  localparam int FRAC_W    = 16;
  localparam int REG_IDX_W = 3;
  localparam int STATUS_W  = 2;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int QPROD_W   = PROD_W - FRAC_W;
  localparam int MAG_W     = DATA_W + 1;
  localparam int DIV_W     = MAG_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUT_FLOOR   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_CEILING = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ACC_FLOOR   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ACC_CEILING = 3'd7;

  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_HIGH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LOW  = 2'd2;

  localparam logic signed [DATA_W-1:0]   S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0]   S_MIN = 32'sh8000_0000;
  localparam logic signed [QPROD_W-1:0]  W_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [QPROD_W-1:0]  W_MIN = 48'shFFFF_8000_0000;

  localparam logic signed [DATA_W-1:0]   GAIN_P_RST      = 32'sd65536;
  localparam logic signed [DATA_W-1:0]   GAIN_I_RST      = 32'sd0;
  localparam logic signed [DATA_W-1:0]   GAIN_D_RST      = 32'sd0;
  localparam logic [PERIOD_W-1:0]        PERIOD_RST      = 31'd655;
  localparam logic signed [DATA_W-1:0]   OUT_FLOOR_RST   = -32'sd6553600;
  localparam logic signed [DATA_W-1:0]   OUT_CEILING_RST = 32'sd6553600;
  localparam logic signed [DATA_W-1:0]   ACC_FLOOR_RST   = -32'sd6553600;
  localparam logic signed [DATA_W-1:0]   ACC_CEILING_RST = 32'sd6553600;

  // saturate a wide signed value to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [QPROD_W-1:0] v);
    if (v > W_MAX) return S_MAX;
    if (v < W_MIN) return S_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W:0] v);
    logic [MAG_W:0] n;
    n = v[MAG_W] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  // apply sign to a quotient magnitude and saturate
  function automatic logic signed [DATA_W-1:0] sat_quot(input logic [DIV_W-1:0] q,
                                                        input logic neg);
    logic [DIV_W-1:0] lim;
    lim = {{(DIV_W-DATA_W){1'b0}}, S_MAX};
    if (neg) begin
      if (q > lim) return S_MIN;
      return -$signed(q[DATA_W-1:0]);
    end
    if (q > lim) return S_MAX;
    return $signed(q[DATA_W-1:0]);
  endfunction

endpackage

// ===== hdl/pidaw_sample_if.sv =====
// Input channel: one controller request per transaction.
interface pidaw_sample_if;
  import pidaw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic                     enable;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] measured;

  modport source (output valid, req_type, enable, target, measured, input ready);
  modport sink (input valid, req_type, enable, target, measured, output ready);
endinterface

// ===== hdl/pidaw_result_if.sv =====
// Output channel: one control output per transaction.
interface pidaw_result_if;
  import pidaw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic [STATUS_W-1:0]      clamp_status;

  modport source (output valid, drive, clamp_status, input ready);
  modport sink (input valid, drive, clamp_status, output ready);
endinterface

// ===== hdl/pid_controller_antiwindup.sv =====
// Positional PID step in Q16.16 with output clamping and back-calculation anti-windup.
//
// Channels: sample (sink) takes req_type, enable, target and measured; result (source)
// gives drive and clamp_status, one transaction out for every transaction in. Both use
// valid/ready; a transaction moves on a rising edge with both high. Registers are written
// through cfg_we/cfg_index/cfg_data, one register per edge; the user must do so only
// while the block is idle, which the block itself does not enforce. A clear request
// (req_type 1) or a disabled step goes from acceptance straight to S_DONE; an active
// step also runs the multiply, accumulate, divide and sum states, and a back-calculation
// division when the output clamps with a nonzero integral gain. One 32x32 multiplier
// and one radix-2 restoring divider (49 steps per division) are shared by a small
// sequencer; the divider sets the step time. sample.ready is high only between steps,
// so one step is in flight at a time. The result sits in an output register; if the
// receiver stalls, the next step is accepted and computed, then held until the
// register empties. Synchronous reset restores the register defaults, clears
// accumulator and last error, and drops result.valid.
module pid_controller_antiwindup (
  input  logic                                 clk,
  input  logic                                 rst,
  pidaw_sample_if.sink                         sample,
  pidaw_result_if.source                       result,
  input  logic                                 cfg_we,
  input  logic [pidaw_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [pidaw_pkg::DATA_W-1:0]         cfg_data
);
  import pidaw_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_P  = 4'd1;
  localparam logic [3:0] S_MUL_A  = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_MUL_I  = 4'd4;
  localparam logic [3:0] S_TERM_I = 4'd5;
  localparam logic [3:0] S_DIV_D  = 4'd6;
  localparam logic [3:0] S_MUL_D  = 4'd7;
  localparam logic [3:0] S_TERM_D = 4'd8;
  localparam logic [3:0] S_SUM    = 4'd9;
  localparam logic [3:0] S_BACK   = 4'd10;
  localparam logic [3:0] S_DIV_A  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state;

  logic signed [DATA_W-1:0] gain_p, gain_i, gain_d;
  logic [PERIOD_W-1:0]      sample_period;
  logic signed [DATA_W-1:0] out_floor, out_ceiling, acc_floor, acc_ceiling;

  logic signed [DATA_W-1:0] accumulator, last_error;
  logic signed [DATA_W-1:0] err, p, it, d, acc, deriv, drive_r;
  logic [STATUS_W-1:0]      status_r;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [QPROD_W-1:0] qprod;

  logic [PERIOD_W-1:0]      dt_eff;
  logic signed [DATA_W:0]   diff_in;
  logic signed [DATA_W-1:0] err_in;
  logic signed [QPROD_W:0]  acc_sum, amax_x, amin_x;
  logic signed [DATA_W-1:0] acc_clamp;
  logic signed [MAG_W:0]    sum_x, omax_x, omin_x, diff_d, diff_b;

  logic                     back_run, div_load, div_neg, div_neg_in, div_ge;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [MAG_W-1:0]         div_mag_in;
  logic [DATA_W-1:0]        div_den, div_den_in;
  logic [DATA_W-1:0]        div_rem;
  logic [DIV_W-1:0]         div_quo;
  logic [DATA_W:0]          div_sh, div_sub;
  logic                     out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= GAIN_P_RST;
      gain_i        <= GAIN_I_RST;
      gain_d        <= GAIN_D_RST;
      sample_period <= PERIOD_RST;
      out_floor     <= OUT_FLOOR_RST;
      out_ceiling   <= OUT_CEILING_RST;
      acc_floor     <= ACC_FLOOR_RST;
      acc_ceiling   <= ACC_CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:      gain_p        <= cfg_data;
        REG_GAIN_I:      gain_i        <= cfg_data;
        REG_GAIN_D:      gain_d        <= cfg_data;
        REG_PERIOD:      sample_period <= cfg_data[PERIOD_W-1:0];
        REG_OUT_FLOOR:   out_floor     <= cfg_data;
        REG_OUT_CEILING: out_ceiling   <= cfg_data;
        REG_ACC_FLOOR:   acc_floor     <= cfg_data;
        REG_ACC_CEILING: acc_ceiling   <= cfg_data;
      endcase
    end
  end

  assign dt_eff  = (sample_period == '0) ? {{(PERIOD_W-1){1'b0}}, 1'b1} : sample_period;
  assign diff_in = {sample.target[DATA_W-1], sample.target}
                 - {sample.measured[DATA_W-1], sample.measured};
  assign err_in  = sat_word({{(QPROD_W-DATA_W-1){diff_in[DATA_W]}}, diff_in});

  // shared multiplier, product registered
  always_comb begin
    mul_a = gain_p;
    mul_b = err;
    unique case (state)
      S_MUL_A: begin
        mul_a = err;
        mul_b = $signed({1'b0, dt_eff});
      end
      S_MUL_I: begin
        mul_a = gain_i;
        mul_b = acc;
      end
      S_MUL_D: begin
        mul_a = gain_d;
        mul_b = deriv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign qprod = prod[PROD_W-1:FRAC_W];

  // integral accumulation and clamp
  assign acc_sum = {{(QPROD_W-DATA_W+1){accumulator[DATA_W-1]}}, accumulator}
                 + {qprod[QPROD_W-1], qprod};
  assign amax_x  = {{(QPROD_W-DATA_W+1){acc_ceiling[DATA_W-1]}}, acc_ceiling};
  assign amin_x  = {{(QPROD_W-DATA_W+1){acc_floor[DATA_W-1]}}, acc_floor};

  always_comb begin
    if (acc_sum > amax_x) acc_clamp = acc_ceiling;
    else if (acc_sum < amin_x) acc_clamp = acc_floor;
    else acc_clamp = acc_sum[DATA_W-1:0];
  end

  // output sum
  assign sum_x  = {{2{p[DATA_W-1]}}, p} + {{2{it[DATA_W-1]}}, it} + {{2{d[DATA_W-1]}}, d};
  assign omax_x = {{2{out_ceiling[DATA_W-1]}}, out_ceiling};
  assign omin_x = {{2{out_floor[DATA_W-1]}}, out_floor};

  // divider operands: derivative or back-calculation
  assign diff_d   = {{2{err[DATA_W-1]}}, err} - {{2{last_error[DATA_W-1]}}, last_error};
  assign diff_b   = {{2{drive_r[DATA_W-1]}}, drive_r} - {{2{p[DATA_W-1]}}, p}
                  - {{2{d[DATA_W-1]}}, d};
  assign back_run = (status_r != STATUS_NONE) && (gain_i != '0);
  assign div_load = (state == S_ACC) || ((state == S_BACK) && back_run);

  always_comb begin
    if (state == S_BACK) begin
      div_mag_in = mag_of(diff_b);
      div_neg_in = diff_b[MAG_W] ^ gain_i[DATA_W-1];
      div_den_in = gain_i[DATA_W-1] ? -gain_i : gain_i;
    end else begin
      div_mag_in = mag_of(diff_d);
      div_neg_in = diff_d[MAG_W];
      div_den_in = {1'b0, dt_eff};
    end
  end

  assign div_sh  = {div_rem, div_quo[DIV_W-1]};
  assign div_sub = div_sh - {1'b0, div_den};
  assign div_ge  = div_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_cnt <= DIV_CNT_W'(DIV_W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_rem <= '0;
      div_quo <= {div_mag_in, {FRAC_W{1'b0}}};
      div_den <= div_den_in;
      div_neg <= div_neg_in;
    end else if (div_cnt != '0) begin
      div_rem <= div_ge ? div_sub[DATA_W-1:0] : div_sh[DATA_W-1:0];
      div_quo <= {div_quo[DIV_W-2:0], div_ge};
    end
  end

  assign sample.ready = (state == S_IDLE);
  assign out_load     = (state == S_DONE) && (!result.valid || result.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      accumulator  <= '0;
      last_error   <= '0;
      result.valid <= 1'b0;
    end else begin
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            if (sample.req_type) begin
              accumulator <= '0;
              last_error  <= '0;
              state       <= S_DONE;
            end else if (!sample.enable) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL_P;
            end
          end
        end
        S_MUL_P:  state <= S_MUL_A;
        S_MUL_A:  state <= S_ACC;
        S_ACC:    state <= S_MUL_I;
        S_MUL_I:  state <= S_TERM_I;
        S_TERM_I: state <= S_DIV_D;
        S_DIV_D: begin
          if (div_cnt == '0) state <= S_MUL_D;
        end
        S_MUL_D:  state <= S_TERM_D;
        S_TERM_D: state <= S_SUM;
        S_SUM:    state <= S_BACK;
        S_BACK: begin
          if (back_run) begin
            state <= S_DIV_A;
          end else begin
            accumulator <= acc;
            last_error  <= err;
            state       <= S_DONE;
          end
        end
        S_DIV_A: begin
          if (div_cnt == '0) begin
            accumulator <= sat_quot(div_quo, div_neg);
            last_error  <= err;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working values
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        err      <= err_in;
        drive_r  <= '0;
        status_r <= STATUS_NONE;
      end
      S_MUL_A:  p     <= sat_word(qprod);
      S_ACC:    acc   <= acc_clamp;
      S_TERM_I: it    <= sat_word(qprod);
      S_DIV_D: begin
        if (div_cnt == '0) deriv <= sat_quot(div_quo, div_neg);
      end
      S_TERM_D: d     <= sat_word(qprod);
      S_SUM: begin
        if (sum_x > omax_x) begin
          drive_r  <= out_ceiling;
          status_r <= STATUS_HIGH;
        end else if (sum_x < omin_x) begin
          drive_r  <= out_floor;
          status_r <= STATUS_LOW;
        end else begin
          drive_r  <= sum_x[DATA_W-1:0];
          status_r <= STATUS_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.drive        <= drive_r;
      result.clamp_status <= status_r;
    end
  end

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> div_cnt == '0)
    else $error("divider still running between steps");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready && sample.req_type |=> accumulator == '0 && last_error == '0)
    else $error("clear request did not zero controller state");

  a_high: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.clamp_status == STATUS_HIGH |-> result.drive == out_ceiling)
    else $error("high clamp without ceiling output");

  a_status: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.clamp_status == STATUS_NONE || result.clamp_status == STATUS_HIGH
                      || result.clamp_status == STATUS_LOW))
    else $error("invalid clamp status");
`endif

endmodule
